@@ rtl/membership_table_merge_defines.svh @@
// Assertion macros shared by the membership table checker.
`ifndef MEMBERSHIP_TABLE_MERGE_DEFINES_SVH
`define MEMBERSHIP_TABLE_MERGE_DEFINES_SVH

// Check a property outside reset.
`define MTM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define MTM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/mtm_pkg.sv @@
// Types and codes of the membership table merge block.
`default_nettype none
package mtm_pkg;

   localparam logic [2:0] OP_UPSERT    = 3'd0;
   localparam logic [2:0] OP_SUSPECT   = 3'd1;
   localparam logic [2:0] OP_DEAD      = 3'd2;
   localparam logic [2:0] OP_ALIVE     = 3'd3;
   localparam logic [2:0] OP_REFUTE    = 3'd4;
   localparam logic [2:0] OP_HEARTBEAT = 3'd5;
   localparam logic [2:0] OP_REMOVE    = 3'd6;
   localparam logic [2:0] OP_ADMIT     = 3'd7;

   localparam logic [1:0] ST_ALIVE   = 2'd0;
   localparam logic [1:0] ST_SUSPECT = 2'd1;
   localparam logic [1:0] ST_DEAD    = 2'd2;
   localparam logic [1:0] ST_JOINING = 2'd3;

   localparam logic [1:0] RES_APPLIED  = 2'd0;
   localparam logic [1:0] RES_IGNORED  = 2'd1;
   localparam logic [1:0] RES_NOTFOUND = 2'd2;
   localparam logic [1:0] RES_FULL     = 2'd3;

   localparam logic [1:0] RING_NONE   = 2'd0;
   localparam logic [1:0] RING_ADD    = 2'd1;
   localparam logic [1:0] RING_REMOVE = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] node_id;
      logic [1:0]  node_state;
      logic [63:0] version_value;
      logic [15:0] suspect_count_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  ring_action;
      logic [63:0] ring_node_id;
      logic [1:0]  entry_state;
      logic [63:0] entry_version;
      logic [15:0] entry_suspect_count;
   } rsp_type;

   // Classified event handed from front to back.
   typedef struct packed {
      req_type req;
      logic    local_op;
      logic    sel0;
      logic    need_scan;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/mtm_fifo.sv @@
// Small register queue used between the stages.
`default_nettype none
module mtm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

@@ rtl/mtm_front.sv @@
// Front end: accept events and classify them for the back end.
`default_nettype none
module mtm_front import mtm_pkg::*; (
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   input  wire logic [63:0] self_id,
   input  wire logic        cmd_full,
   output logic             cmd_push,
   output cmd_type          cmd
);
   logic id_local;

   assign id_local = (req_data.node_id == self_id);
   assign req_full = cmd_full;
   assign cmd_push = req_push;

   always_comb begin
      cmd.req      = req_data;
      cmd.local_op = (req_data.op == OP_REFUTE) || (req_data.op == OP_HEARTBEAT) ||
                     ((req_data.op == OP_UPSERT) && id_local);
      cmd.sel0     = cmd.local_op || id_local;
      cmd.need_scan = !cmd.local_op;
   end
endmodule
`default_nettype wire

@@ rtl/mtm_back.sv @@
// Back end: table scan, merge rules and table update.
`default_nettype none
module mtm_back import mtm_pkg::*; #(
   parameter int MAX_NODES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] self_id,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output logic             cmd_pop,
   input  wire logic        rsp_full,
   output logic             rsp_push,
   output rsp_type          rsp
);
   localparam int IDXW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNTW = $clog2(MAX_NODES + 1);

   typedef struct packed {
      logic [63:0] id;
      logic [1:0]  state;
      logic [63:0] version;
      logic [15:0] count;
   } row_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_CMP, S_LAST_RD, S_LAST_WR, S_EXEC
   } state_type;

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [CNTW-1:0] k_ff, k_in, len_ff, len_in;
   logic [CNTW-1:0] ecount_ff, ecount_in, bcount_ff, bcount_in;
   logic          ef_ff, ef_in, bf_ff, bf_in;
   logic [IDXW-1:0] eidx_ff, eidx_in, bidx_ff, bidx_in;
   row_type       erow_ff, erow_in;
   logic [1:0]    s0_state_ff, s0_state_in;
   logic [63:0]   s0_ver_ff, s0_ver_in;
   logic [15:0]   s0_cnt_ff, s0_cnt_in;

   row_type       ent_mem [MAX_NODES];
   logic [63:0]   bar_mem [MAX_NODES];
   row_type       ent_rdata_ff, ent_wdata;
   logic [63:0]   bar_rdata_ff, bar_wdata;
   logic [IDXW-1:0] ent_raddr, ent_waddr, bar_raddr, bar_waddr;
   logic          ent_we, bar_we;
   logic [CNTW-1:0] bar_last;

   // Execute-step signals.
   logic [1:0]    cur_state, new_state;
   logic [63:0]   cur_ver, new_ver;
   logic [15:0]   cur_cnt, new_cnt;
   logic          ef, out_ok, wr, app, res, win;

   function automatic logic in_ring(input logic [1:0] s);
      in_ring = (s == ST_ALIVE) || (s == ST_JOINING);
   endfunction

   assign bar_last  = bcount_ff - CNTW'(1);
   assign ent_raddr = k_ff[IDXW-1:0];
   assign bar_raddr = (state_ff == S_LAST_RD) ? bar_last[IDXW-1:0] : k_ff[IDXW-1:0];

   always_comb begin
      cur_state = cmd_ff.sel0 ? s0_state_ff : erow_ff.state;
      cur_ver   = cmd_ff.sel0 ? s0_ver_ff   : erow_ff.version;
      cur_cnt   = cmd_ff.sel0 ? s0_cnt_ff   : erow_ff.count;
      ef        = cmd_ff.sel0 || ef_ff;
      new_state = cur_state;
      new_ver   = cur_ver;
      new_cnt   = cur_cnt;
      out_ok    = ef;
      wr        = 1'b0;
      app       = 1'b0;
      res       = 1'b0;
      win       = 1'b0;
      rsp.status       = RES_APPLIED;
      rsp.ring_action  = RING_NONE;
      rsp.ring_node_id = cmd_ff.local_op ? self_id : cmd_ff.req.node_id;
      bar_we    = 1'b0;
      bar_waddr = bidx_ff;
      bar_wdata = bar_rdata_ff;
      bcount_in = bcount_ff;
      ecount_in = ecount_ff;

      if (state_ff == S_LAST_WR) begin
         bar_we = 1'b1;
      end

      if (state_ff == S_EXEC) begin
         case (cmd_ff.req.op)
            OP_UPSERT: begin
               if (cmd_ff.local_op) begin
                  if (cmd_ff.req.node_state == ST_SUSPECT ||
                      cmd_ff.req.node_state == ST_DEAD) begin
                     wr = 1'b1;
                     if (cmd_ff.req.version_value >= cur_ver) begin
                        new_ver = cmd_ff.req.version_value + 64'd1;
                     end
                     new_state = ST_ALIVE;
                     new_cnt   = '0;
                  end else begin
                     rsp.status = RES_IGNORED;
                  end
               end else if (!ef) begin
                  if (ecount_ff >= CNTW'(MAX_NODES)) begin
                     rsp.status = RES_FULL;
                     out_ok     = 1'b0;
                  end else begin
                     app       = 1'b1;
                     out_ok    = 1'b1;
                     ecount_in = ecount_ff + CNTW'(1);
                     new_state = cmd_ff.req.node_state;
                     new_ver   = cmd_ff.req.version_value;
                     new_cnt   = cmd_ff.req.suspect_count_in;
                     if (in_ring(cmd_ff.req.node_state) && !bf_ff) begin
                        rsp.ring_action = RING_ADD;
                     end
                  end
               end else begin
                  res = (cmd_ff.req.node_state == ST_ALIVE) &&
                        (cur_state == ST_DEAD || cur_state == ST_SUSPECT) &&
                        (cmd_ff.req.version_value >= cur_ver);
                  win = (cmd_ff.req.version_value > cur_ver) || res;
                  if (win) begin
                     wr        = 1'b1;
                     new_state = cmd_ff.req.node_state;
                     new_ver   = cmd_ff.req.version_value;
                     new_cnt   = res ? 16'd0 : cmd_ff.req.suspect_count_in;
                     if (!in_ring(cur_state) && in_ring(cmd_ff.req.node_state)) begin
                        if (!bf_ff) begin
                           rsp.ring_action = RING_ADD;
                        end
                     end else if (in_ring(cur_state) && !in_ring(cmd_ff.req.node_state)) begin
                        rsp.ring_action = RING_REMOVE;
                     end
                  end else begin
                     rsp.status = RES_IGNORED;
                  end
               end
            end
            OP_SUSPECT: begin
               if (!ef) begin
                  rsp.status = RES_NOTFOUND;
               end else if (cur_state == ST_ALIVE) begin
                  wr        = 1'b1;
                  new_state = ST_SUSPECT;
                  new_cnt   = (cur_cnt == 16'hFFFF) ? cur_cnt : cur_cnt + 16'd1;
                  new_ver   = cur_ver + 64'd1;
                  rsp.ring_action = RING_REMOVE;
               end else begin
                  rsp.status = RES_IGNORED;
               end
            end
            OP_DEAD: begin
               if (!ef) begin
                  rsp.status = RES_NOTFOUND;
               end else begin
                  wr        = 1'b1;
                  new_state = ST_DEAD;
                  new_ver   = cur_ver + 64'd1;
                  rsp.ring_action = RING_REMOVE;
               end
            end
            OP_ALIVE: begin
               if (!ef) begin
                  rsp.status = RES_NOTFOUND;
               end else begin
                  wr        = 1'b1;
                  new_state = ST_ALIVE;
                  new_cnt   = '0;
                  if (cmd_ff.req.version_value > cur_ver) begin
                     new_ver = cmd_ff.req.version_value;
                  end
                  if (cur_state != ST_ALIVE && !bf_ff) begin
                     rsp.ring_action = RING_ADD;
                  end
               end
            end
            OP_REFUTE: begin
               wr = 1'b1;
               if (cmd_ff.req.version_value >= cur_ver) begin
                  new_ver = cmd_ff.req.version_value + 64'd1;
               end
               new_state = ST_ALIVE;
               new_cnt   = '0;
            end
            OP_HEARTBEAT: begin
               wr      = 1'b1;
               new_ver = cur_ver + 64'd1;
            end
            OP_REMOVE: begin
               if (!bf_ff) begin
                  if (bcount_ff < CNTW'(MAX_NODES)) begin
                     bar_we    = 1'b1;
                     bar_waddr = bcount_ff[IDXW-1:0];
                     bar_wdata = cmd_ff.req.node_id;
                     bcount_in = bcount_ff + CNTW'(1);
                  end else begin
                     rsp.status = RES_FULL;
                  end
               end
               rsp.ring_action = RING_REMOVE;
            end
            OP_ADMIT: begin
               if (!bf_ff) begin
                  rsp.status = RES_IGNORED;
               end else begin
                  bcount_in = bcount_ff - CNTW'(1);
                  if (ef && in_ring(cur_state)) begin
                     rsp.ring_action = RING_ADD;
                  end
               end
            end
            default: begin
               rsp.status = RES_IGNORED;
            end
         endcase
      end

      rsp.entry_state         = out_ok ? new_state : 2'd0;
      rsp.entry_version       = out_ok ? new_ver   : 64'd0;
      rsp.entry_suspect_count = out_ok ? new_cnt   : 16'd0;
   end

   assign rsp_push  = (state_ff == S_EXEC);
   assign ent_we    = rsp_push && ((wr && !cmd_ff.sel0) || app);
   assign ent_waddr = app ? ecount_ff[IDXW-1:0] : eidx_ff;
   assign ent_wdata = '{id: cmd_ff.req.node_id, state: new_state,
                        version: new_ver, count: new_cnt};

   always_comb begin
      s0_state_in = s0_state_ff;
      s0_ver_in   = s0_ver_ff;
      s0_cnt_in   = s0_cnt_ff;
      if (rsp_push && wr && cmd_ff.sel0) begin
         s0_state_in = new_state;
         s0_ver_in   = new_ver;
         s0_cnt_in   = new_cnt;
      end
   end

   // Sequencer: pop, scan both stores unless the event is local, fix up the barred set on an admit, execute.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      k_in     = k_ff;
      len_in   = len_ff;
      ef_in    = ef_ff;
      bf_in    = bf_ff;
      eidx_in  = eidx_ff;
      bidx_in  = bidx_ff;
      erow_in  = erow_ff;
      cmd_pop  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               k_in    = '0;
               len_in  = (ecount_ff > bcount_ff) ? ecount_ff : bcount_ff;
               ef_in   = 1'b0;
               bf_in   = 1'b0;
               state_in = cmd.need_scan ? S_RD : S_EXEC;
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (k_ff != '0 && k_ff < ecount_ff && !ef_ff &&
                ent_rdata_ff.id == cmd_ff.req.node_id) begin
               ef_in   = 1'b1;
               eidx_in = k_ff[IDXW-1:0];
               erow_in = ent_rdata_ff;
            end
            if (k_ff < bcount_ff && !bf_ff && bar_rdata_ff == cmd_ff.req.node_id) begin
               bf_in   = 1'b1;
               bidx_in = k_ff[IDXW-1:0];
            end
            if (k_ff == len_ff - CNTW'(1)) begin
               state_in = (cmd_ff.req.op == OP_ADMIT && bf_in) ? S_LAST_RD : S_EXEC;
            end else begin
               k_in     = k_ff + CNTW'(1);
               state_in = S_RD;
            end
         end
         S_LAST_RD: begin
            state_in = S_LAST_WR;
         end
         S_LAST_WR: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ecount_ff   <= CNTW'(1);
         bcount_ff   <= '0;
         s0_state_ff <= ST_ALIVE;
         s0_ver_ff   <= 64'd1;
         s0_cnt_ff   <= '0;
         ef_ff       <= 1'b0;
         bf_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ecount_ff   <= ecount_in;
         bcount_ff   <= bcount_in;
         s0_state_ff <= s0_state_in;
         s0_ver_ff   <= s0_ver_in;
         s0_cnt_ff   <= s0_cnt_in;
         ef_ff       <= ef_in;
         bf_ff       <= bf_in;
      end
      cmd_ff  <= cmd_in;
      k_ff    <= k_in;
      len_ff  <= len_in;
      eidx_ff <= eidx_in;
      bidx_ff <= bidx_in;
      erow_ff <= erow_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rdata_ff <= ent_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (bar_we) begin
         bar_mem[bar_waddr] <= bar_wdata;
      end
      bar_rdata_ff <= bar_mem[bar_raddr];
   end
endmodule
`default_nettype wire

@@ rtl/membership_table_merge.sv @@
// Membership table merge block: top level.
// Each event is scanned, merged and answered before the next leaves the queue; the scan
//   covers L entries, L the larger of the table fill and the barred-id count; refute,
//   heartbeat and local upserts skip the scan. An admit of a barred id adds steps that
//   read the last barred id and move it into the freed slot before the result.
// Reset: synchronous; table holds only the local slot (alive, version 1).
`default_nettype none
module membership_table_merge import mtm_pkg::*; #(
   parameter int MAX_NODES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [63:0] csr_data
);
   logic [63:0] self_id_ff, self_id_in;
   cmd_type     front_cmd, back_cmd;
   logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
   rsp_type     back_rsp;
   logic        rsp_push, rsp_full;

   // Config beats land at once; slot zero's id is this register.
   assign csr_ready  = 1'b1;
   assign self_id_in = (csr_valid && csr_ready) ? csr_data : self_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff <= '0;
      end else begin
         self_id_ff <= self_id_in;
      end
   end

   // Front: accept beats and tag them with their class.
   mtm_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .self_id  (self_id_ff),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (front_cmd)
   );

   // Hold classified events so the front can take beats during a scan until the queue fills.
   mtm_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty)
   );

   // Back: scan, merge, write back, emit one result per event.
   mtm_back #(.MAX_NODES(MAX_NODES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .self_id   (self_id_ff),
      .cmd_valid (!cmd_empty),
      .cmd       (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   // Result queue parts the back end from a stalled consumer.
   mtm_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );
endmodule
`default_nettype wire

@@ rtl/mtm_checker.sv @@
// Port-level checks of the membership table merge block, with bind.
`default_nettype none
`include "membership_table_merge_defines.svh"
module mtm_checker import mtm_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_push,
   input wire req_type     req_data,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire rsp_type     rsp_data,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [63:0] csr_data
);
   `MTM_ASSERT_ALWAYS(a_empty_after_reset, reset |=> rsp_empty, "result after reset")
   `MTM_ASSERT(a_ring_code, !rsp_empty |-> rsp_data.ring_action != 2'd3, "bad ring code")
   `MTM_ASSERT(a_notfound_quiet,
      (!rsp_empty && rsp_data.status == RES_NOTFOUND) |->
      (rsp_data.ring_action == RING_NONE && rsp_data.entry_version == 64'd0),
      "not found with action")
   `MTM_ASSERT(a_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)),
      "result dropped")
endmodule

bind membership_table_merge mtm_checker u_mtm_checker (.*);
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the membership table merge block.
`default_nettype none
module tb_top import mtm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = 64;
   // Slowest event: a full scan of all table slots plus the admit fix-up; round up.
   localparam int SETTLE_CYCLES = 160;
   // Idle cycles without any beat before the run is declared hung.
   localparam int HANG_LIMIT = 6000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   req_type req_data = '0;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [63:0] csr_data = '0;

   always #6 clock = ~clock;

   membership_table_merge #(.MAX_NODES(TABLE_SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // ---------------------------------------------------------------------
   // Shadow membership table: mirrors the block's table and barred set.
   // ---------------------------------------------------------------------
   logic [63:0] shadow_self_id;
   logic [63:0] shadow_ids [TABLE_SLOTS];
   logic [1:0]  shadow_states [TABLE_SLOTS];
   logic [63:0] shadow_versions [TABLE_SLOTS];
   logic [15:0] shadow_counts [TABLE_SLOTS];
   int          shadow_fill;
   logic [63:0] shadow_barred [TABLE_SLOTS];
   int          shadow_barred_fill;

   function automatic int lookup_slot(logic [63:0] id);
      for (int i = 0; i < shadow_fill; i++)
         if (shadow_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic int find_bar(logic [63:0] id);
      for (int i = 0; i < shadow_barred_fill; i++)
         if (shadow_barred[i] == id) return i;
      return -1;
   endfunction

   function automatic bit on_ring(logic [1:0] s);
      return s == ST_ALIVE || s == ST_JOINING;
   endfunction

   // Local node answers a rumor about itself: bump past the peer version.
   function automatic void refute_local(logic [63:0] peer);
      if (peer >= shadow_versions[0]) shadow_versions[0] = peer + 64'd1;
      shadow_states[0] = ST_ALIVE;
      shadow_counts[0] = '0;
   endfunction

   // Apply one membership event to the shadow table and return its outcome.
   function automatic rsp_type merge_event(req_type r);
      rsp_type o;
      int idx;
      int b;
      logic [1:0] old;
      bit revive;
      o = '0;
      o.status = RES_APPLIED;
      o.ring_action = RING_NONE;
      o.ring_node_id = r.node_id;
      idx = -1;
      if (r.op == OP_REFUTE || r.op == OP_HEARTBEAT ||
          (r.op == OP_UPSERT && r.node_id == shadow_self_id)) begin
         o.ring_node_id = shadow_self_id;
         idx = 0;
         if (r.op == OP_REFUTE) refute_local(r.version_value);
         else if (r.op == OP_HEARTBEAT) shadow_versions[0] += 64'd1;
         else if (r.node_state == ST_SUSPECT || r.node_state == ST_DEAD)
            refute_local(r.version_value);
         else o.status = RES_IGNORED;
      end else if (r.op == OP_UPSERT) begin
         idx = lookup_slot(r.node_id);
         if (idx < 0) begin
            if (shadow_fill >= TABLE_SLOTS) begin
               o.status = RES_FULL;
            end else begin
               idx = shadow_fill++;
               shadow_ids[idx] = r.node_id;
               shadow_states[idx] = r.node_state;
               shadow_versions[idx] = r.version_value;
               shadow_counts[idx] = r.suspect_count_in;
               if (on_ring(r.node_state) && find_bar(r.node_id) < 0)
                  o.ring_action = RING_ADD;
            end
         end else begin
            old = shadow_states[idx];
            // Resurrect: an alive record revives a suspect or dead entry.
            revive = r.node_state == ST_ALIVE && (old == ST_DEAD || old == ST_SUSPECT)
                     && r.version_value >= shadow_versions[idx];
            if (r.version_value > shadow_versions[idx] || revive) begin
               shadow_states[idx] = r.node_state;
               shadow_versions[idx] = r.version_value;
               shadow_counts[idx] = revive ? 16'd0 : r.suspect_count_in;
               if (!on_ring(old) && on_ring(r.node_state)) begin
                  if (find_bar(r.node_id) < 0) o.ring_action = RING_ADD;
               end else if (on_ring(old) && !on_ring(r.node_state)) begin
                  o.ring_action = RING_REMOVE;
               end
            end else begin
               o.status = RES_IGNORED;
            end
         end
      end else if (r.op == OP_SUSPECT || r.op == OP_DEAD || r.op == OP_ALIVE) begin
         idx = lookup_slot(r.node_id);
         if (idx < 0) begin
            o.status = RES_NOTFOUND;
         end else if (r.op == OP_SUSPECT) begin
            if (shadow_states[idx] == ST_ALIVE) begin
               shadow_states[idx] = ST_SUSPECT;
               if (shadow_counts[idx] != 16'hFFFF) shadow_counts[idx] += 16'd1;
               shadow_versions[idx] += 64'd1;
               o.ring_action = RING_REMOVE;
            end else begin
               o.status = RES_IGNORED;
            end
         end else if (r.op == OP_DEAD) begin
            shadow_states[idx] = ST_DEAD;
            shadow_versions[idx] += 64'd1;
            o.ring_action = RING_REMOVE;
         end else begin
            old = shadow_states[idx];
            shadow_states[idx] = ST_ALIVE;
            shadow_counts[idx] = '0;
            if (r.version_value > shadow_versions[idx])
               shadow_versions[idx] = r.version_value;
            if (old != ST_ALIVE && find_bar(r.node_id) < 0) o.ring_action = RING_ADD;
         end
      end else if (r.op == OP_REMOVE) begin
         if (find_bar(r.node_id) < 0) begin
            if (shadow_barred_fill < TABLE_SLOTS)
               shadow_barred[shadow_barred_fill++] = r.node_id;
            else o.status = RES_FULL;
         end
         o.ring_action = RING_REMOVE;
         idx = lookup_slot(r.node_id);
      end else begin
         b = find_bar(r.node_id);
         idx = lookup_slot(r.node_id);
         if (b < 0) begin
            o.status = RES_IGNORED;
         end else begin
            // Close the gap with the last barred id.
            shadow_barred_fill--;
            shadow_barred[b] = shadow_barred[shadow_barred_fill];
            if (idx >= 0 && on_ring(shadow_states[idx])) o.ring_action = RING_ADD;
         end
      end
      if (idx >= 0) begin
         o.entry_state = shadow_states[idx];
         o.entry_version = shadow_versions[idx];
         o.entry_suspect_count = shadow_counts[idx];
      end
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: predict on each accepted request beat, check each result.
   // ---------------------------------------------------------------------
   typedef struct {
      bit      fixed;
      rsp_type want;
   } typed_want;

   typed_want   typed_wants[$];  // fed by the driver in send order
   rsp_type     pending_results[$];
   int          mismatches = 0;
   int          events_accepted = 0;
   int          results_checked = 0;
   int          full_seen = 0;
   int          idle_cycles = 0;

   always @(posedge clock) begin
      rsp_type guess;
      rsp_type want;
      typed_want tw;
      if (reset) begin
         shadow_ids[0] = '0;
         shadow_states[0] = ST_ALIVE;
         shadow_versions[0] = 64'd1;
         shadow_counts[0] = '0;
         shadow_fill = 1;
         shadow_barred_fill = 0;
         shadow_self_id = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            shadow_self_id = csr_data;
            shadow_ids[0] = csr_data;
         end
         if (req_push && !req_full) begin
            guess = merge_event(req_data);
            tw = typed_wants.pop_front();
            pending_results.push_back(tw.fixed ? tw.want : guess);
            events_accepted++;
         end
         if (rsp_pop && !rsp_empty) begin
            results_checked++;
            if (rsp_data.status == RES_FULL) full_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("%0t: unexpected result beat %p", $realtime, rsp_data);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.ring_action !== want.ring_action ||
                   rsp_data.ring_node_id !== want.ring_node_id ||
                   rsp_data.entry_state !== want.entry_state ||
                   rsp_data.entry_version !== want.entry_version ||
                   rsp_data.entry_suspect_count !== want.entry_suspect_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result %0d mismatch\n  want %p\n  got  %p",
                              $realtime, results_checked, want, rsp_data);
               end
            end
         end
      end
   end

   // Hang detection: count cycles with no beat on any channel.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("timeout: no beat for %0d cycles", HANG_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Receiver: rotate between always-pop, coin-flip and long stall windows.
   int rx_cycle = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 257) % 3)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= 1'($urandom_range(0, 1));
         default: rsp_pop <= (rx_cycle % 23) >= 17;
      endcase
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   int burst_left = 0;

   function automatic req_type make_event(logic [2:0] op, logic [63:0] id, logic [1:0] st,
                                          logic [63:0] ver, logic [15:0] cnt);
      req_type r;
      r.op = op;
      r.node_id = id;
      r.node_state = st;
      r.version_value = ver;
      r.suspect_count_in = cnt;
      return r;
   endfunction

   function automatic rsp_type make_result(logic [1:0] status, logic [1:0] ring,
                                           logic [63:0] rid, logic [1:0] st,
                                           logic [63:0] ver, logic [15:0] cnt);
      rsp_type o;
      o.status = status;
      o.ring_action = ring;
      o.ring_node_id = rid;
      o.entry_state = st;
      o.entry_version = ver;
      o.entry_suspect_count = cnt;
      return o;
   endfunction

   // Hold push until the beat is taken, then maybe drop it for a gap.
   task automatic send_event(req_type r, bit fixed, rsp_type want);
      typed_want tw;
      int gap;
      tw.fixed = fixed;
      tw.want = want;
      typed_wants.push_back(tw);
      req_data <= r;
      req_push <= 1'b1;
      @(negedge clock);
      while (req_full) @(negedge clock);
      @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drain every outstanding result, then let the block go quiet.
   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_local_id(logic [63:0] value);
      drain_results();
      csr_data <= value;
      csr_valid <= 1'b1;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   logic [63:0] id_pool [$];
   int          op_weight [8];

   function automatic logic [2:0] pick_op();
      int total;
      int roll;
      total = 0;
      foreach (op_weight[i]) total += op_weight[i];
      roll = $urandom_range(0, total - 1);
      for (int i = 0; i < 8; i++) begin
         if (roll < op_weight[i]) return 3'(i);
         roll -= op_weight[i];
      end
      return OP_UPSERT;
   endfunction

   // Mostly pool ids with versions near the held one, so merges go both ways.
   function automatic req_type random_event();
      req_type r;
      int slot;
      int pick;
      r.op = pick_op();
      pick = $urandom_range(0, 99);
      if (pick < 85) r.node_id = id_pool[$urandom_range(0, id_pool.size() - 1)];
      else if (pick < 92) r.node_id = shadow_self_id;
      else r.node_id = {$urandom, $urandom};
      r.node_state = 2'($urandom_range(0, 3));
      slot = lookup_slot(r.node_id);
      pick = $urandom_range(0, 99);
      if (slot >= 0 && pick < 55)
         r.version_value = shadow_versions[slot] + 64'($urandom_range(0, 3)) - 64'd1;
      else if (pick < 80) r.version_value = 64'($urandom_range(0, 40));
      else if (pick < 95) r.version_value = {$urandom, $urandom};
      else r.version_value = '1;
      r.suspect_count_in = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
      return r;
   endfunction

   task automatic run_random(int count, int pool_size);
      rsp_type none;
      none = '0;
      id_pool.delete();
      repeat (pool_size) id_pool.push_back({$urandom, $urandom});
      for (int n = 0; n < count; n++) begin
         // Stop once mid-phase and let every result come back.
         if (n == count / 2) drain_results();
         send_event(random_event(), 1'b0, none);
      end
   endtask

   typedef struct {
      req_type ev;
      bit      fixed;
      rsp_type want;
   } directed_row;

   directed_row directed [$];

   task automatic add_row(req_type ev, bit fixed, rsp_type want);
      directed_row row;
      row.ev = ev;
      row.fixed = fixed;
      row.want = want;
      directed.push_back(row);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      logic [63:0] top_id;
      logic [63:0] mid_id;
      logic [63:0] odd_id;
      rsp_type none;
      top_id = '1;
      mid_id = 64'h5555_5555_5555_5555;
      odd_id = 64'hAAAA_AAAA_AAAA_AAAA;
      none = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, local id still zero from reset.
      add_row(make_event(OP_HEARTBEAT, 64'd9, ST_DEAD, 64'd0, 16'd0), 1,
              make_result(RES_APPLIED, RING_NONE, 64'd0, ST_ALIVE, 64'd2, 16'd0));
      add_row(make_event(OP_UPSERT, 64'd0, ST_ALIVE, 64'd50, 16'd1), 1,
              make_result(RES_IGNORED, RING_NONE, 64'd0, ST_ALIVE, 64'd2, 16'd0));
      add_row(make_event(OP_UPSERT, 64'd0, ST_SUSPECT, 64'd5, 16'd1), 1,
              make_result(RES_APPLIED, RING_NONE, 64'd0, ST_ALIVE, 64'd6, 16'd0));
      add_row(make_event(OP_SUSPECT, 64'd5, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_NOTFOUND, RING_NONE, 64'd5, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_DEAD, 64'd5, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_NOTFOUND, RING_NONE, 64'd5, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_ALIVE, 64'd5, ST_ALIVE, 64'd3, 16'd0), 1,
              make_result(RES_NOTFOUND, RING_NONE, 64'd5, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_ADMIT, 64'd5, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_IGNORED, RING_NONE, 64'd5, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_UPSERT, top_id, ST_ALIVE, '1, 16'hFFFF), 1,
              make_result(RES_APPLIED, RING_ADD, top_id, ST_ALIVE, '1, 16'hFFFF));
      // Suspect count saturates while the version wraps to zero.
      add_row(make_event(OP_SUSPECT, top_id, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_APPLIED, RING_REMOVE, top_id, ST_SUSPECT, 64'd0, 16'hFFFF));
      add_row(make_event(OP_SUSPECT, top_id, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_IGNORED, RING_NONE, top_id, ST_SUSPECT, 64'd0, 16'hFFFF));
      // Resurrect at an equal version clears the count.
      add_row(make_event(OP_UPSERT, top_id, ST_ALIVE, 64'd0, 16'h00FF), 1,
              make_result(RES_APPLIED, RING_ADD, top_id, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_REMOVE, top_id, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_APPLIED, RING_REMOVE, top_id, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_UPSERT, top_id, ST_DEAD, 64'd7, 16'd3), 1,
              make_result(RES_APPLIED, RING_REMOVE, top_id, ST_DEAD, 64'd7, 16'd3));
      // Barred node comes back alive but stays off the ring.
      add_row(make_event(OP_ALIVE, top_id, ST_ALIVE, 64'd2, 16'd0), 1,
              make_result(RES_APPLIED, RING_NONE, top_id, ST_ALIVE, 64'd7, 16'd0));
      add_row(make_event(OP_ADMIT, top_id, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_APPLIED, RING_ADD, top_id, ST_ALIVE, 64'd7, 16'd0));
      // Refute of a maximal peer version wraps the local version.
      add_row(make_event(OP_REFUTE, odd_id, ST_JOINING, '1, 16'hFFFF), 1,
              make_result(RES_APPLIED, RING_NONE, 64'd0, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_UPSERT, mid_id, ST_JOINING, 64'd3, 16'h1234), 1,
              make_result(RES_APPLIED, RING_ADD, mid_id, ST_JOINING, 64'd3, 16'h1234));
      add_row(make_event(OP_UPSERT, mid_id, ST_SUSPECT, 64'd3, 16'd0), 1,
              make_result(RES_IGNORED, RING_NONE, mid_id, ST_JOINING, 64'd3, 16'h1234));
      add_row(make_event(OP_DEAD, mid_id, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_APPLIED, RING_REMOVE, mid_id, ST_DEAD, 64'd4, 16'h1234));
      add_row(make_event(OP_UPSERT, mid_id, ST_SUSPECT, 64'd4, 16'd0), 1,
              make_result(RES_IGNORED, RING_NONE, mid_id, ST_DEAD, 64'd4, 16'h1234));
      add_row(make_event(OP_REMOVE, odd_id, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_APPLIED, RING_REMOVE, odd_id, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_REMOVE, odd_id, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_APPLIED, RING_REMOVE, odd_id, ST_ALIVE, 64'd0, 16'd0));
      add_row(make_event(OP_ADMIT, odd_id, ST_ALIVE, 64'd0, 16'd0), 0, none);
      add_row(make_event(OP_HEARTBEAT, 64'd0, ST_ALIVE, 64'd0, 16'd0), 1,
              make_result(RES_APPLIED, RING_NONE, 64'd0, ST_ALIVE, 64'd1, 16'd0));
      foreach (directed[i]) send_event(directed[i].ev, directed[i].fixed, directed[i].want);

      // Small pool: dense merges on a few ids, local id zero.
      op_weight = '{30, 12, 8, 12, 5, 5, 10, 8};
      run_random(500, 24);

      // Local id all ones; wide pool to fill both the table and the barred set.
      write_local_id('1);
      op_weight = '{45, 6, 4, 6, 3, 3, 30, 3};
      run_random(450, 90);

      // Random local id, small pool again.
      write_local_id({$urandom, $urandom});
      op_weight = '{30, 12, 8, 12, 5, 5, 10, 10};
      run_random(400, 16);

      drain_results();
      $display("covered %0d events, %0d results checked, %0d table or bar full outcomes",
               events_accepted, results_checked, full_seen);
      $display("local id written as all ones and random after the reset value of zero");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
